// ===== rtl/mpdt_pkg.sv =====
// shared types, constants and command codes of the four-pump dose timer
package mpdt_pkg;

  // field widths
  localparam int CMD_W     = 3;
  localparam int PUMP_W    = 2;
  localparam int VOL_W     = 24;
  localparam int FLOW_W    = 16;
  localparam int DOSED_W   = 19;
  localparam int PUMP_ON_W = 4;
  localparam int CNT_W     = 22;

  // configuration port
  localparam int FLOW_REGS  = 4;
  localparam int FLOW_IDX_W = 2;
  localparam int CFG_IDX_W  = 8;
  localparam logic [FLOW_W-1:0] FLOW_RESET = 16'd6000;

  // default pump count for the top level
  localparam int PUMP_COUNT_DEF = 4;

  // dose arithmetic
  localparam int RT_W       = 19;
  localparam int PROD_W     = VOL_W + FLOW_W;
  localparam int MUL_STEPS  = VOL_W;
  localparam int DIV_STEPS  = RT_W;
  localparam int STEP_W     = 5;
  localparam logic [FLOW_W-1:0]  MS_PER_MIN    = 16'd60000;
  localparam logic [RT_W-1:0]    DOSE_CAP_MS   = 19'd280000;
  localparam logic [CNT_W-1:0]   MANUAL_CAP_MS = 22'd3600000;
  localparam logic [DOSED_W-1:0] DOSED_MAX     = 19'd305830;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DOSE     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_START    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP_ALL = 3'd4;

  // input item
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [PUMP_W-1:0] pump;
    logic [VOL_W-1:0]  volume_centiml;
  } mpdt_in_t;

  // result item
  typedef struct packed {
    logic [DOSED_W-1:0]   dosed_centiml;
    logic [PUMP_ON_W-1:0] pump_on;
  } mpdt_out_t;

  // request to the serial dose unit
  typedef struct packed {
    logic              start;
    logic [FLOW_W-1:0] flow;
    logic [VOL_W-1:0]  volume;
  } arith_req_t;

  // answer of the serial dose unit
  typedef struct packed {
    logic               busy;
    logic               done;
    logic [RT_W-1:0]    runtime;
    logic [DOSED_W-1:0] dosed;
  } arith_rsp_t;

endpackage

// ===== rtl/multi_pump_dose_timer.sv =====
// top level of the multi-pump dose timer: command sequencer, pump counters, flow registers
//
// One result item per input item, one item at a time. A tick item walks the pump counters
// with one shared decrementer, one pump per cycle. A dose item runs through the bit-serial
// dose unit: a 24-step shift-add multiply, a range check, a 19-step restoring divide and a
// cap for the run time, then the same again for the delivered volume (the first divide is
// skipped when the run time hits the cap before division, and a zero flow goes straight to
// the end). Manual start, manual stop, stop-all and unknown codes go straight from the
// accept to the result stage. A finished result sits in the output register while the next
// item is taken; a new result waits until that register is free. Flow registers are written
// in any cycle, and a dose in progress keeps the flow it started with; indexes above 3 are
// taken and ignored.
module multi_pump_dose_timer #(
  parameter int PUMP_COUNT = mpdt_pkg::PUMP_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mpdt_pkg::mpdt_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mpdt_pkg::mpdt_out_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mpdt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mpdt_pkg::FLOW_W-1:0]       cfg_data
);

  localparam int IDX_W = (PUMP_COUNT > 1) ? $clog2(PUMP_COUNT) : 1;
  localparam int PAD_W = (PUMP_COUNT < mpdt_pkg::PUMP_ON_W) ? mpdt_pkg::PUMP_ON_W : PUMP_COUNT;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_TICK = 2'd1;
  localparam logic [1:0] T_DOSE = 2'd2;
  localparam logic [1:0] T_FIN  = 2'd3;

  logic [1:0]                       state_r, state_nxt;
  logic [mpdt_pkg::CMD_W-1:0]       cmd_r, cmd_nxt;
  logic [mpdt_pkg::PUMP_W-1:0]      pump_r, pump_nxt;
  logic [mpdt_pkg::RT_W-1:0]        runtime_r, runtime_nxt;
  logic [mpdt_pkg::DOSED_W-1:0]     dosed_r, dosed_nxt;
  logic [IDX_W-1:0]                 tick_idx_r, tick_idx_nxt;
  logic [mpdt_pkg::CNT_W-1:0]       remaining_r [PUMP_COUNT];
  logic [mpdt_pkg::CNT_W-1:0]       remaining_nxt [PUMP_COUNT];
  logic [PUMP_COUNT-1:0]            active_r, active_nxt;
  logic [mpdt_pkg::FLOW_W-1:0]      flow_r [mpdt_pkg::FLOW_REGS];
  logic [mpdt_pkg::FLOW_W-1:0]      flow_nxt [mpdt_pkg::FLOW_REGS];
  mpdt_pkg::mpdt_out_t              out_r, out_nxt;
  logic                             out_valid_r, out_valid_nxt;

  mpdt_pkg::arith_req_t             arith_req;
  mpdt_pkg::arith_rsp_t             arith_rsp;

  logic                             pump_ok;
  logic                             pump_ok_in;
  logic                             out_free;
  logic [mpdt_pkg::CNT_W-1:0]       tick_cur;
  logic [mpdt_pkg::CNT_W-1:0]       tick_dec;
  logic [PAD_W-1:0]                 active_pad;

  // serial dose arithmetic
  mpdt_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (arith_req),
    .rsp   (arith_rsp)
  );

  assign in_ready   = (state_r == T_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign pump_ok    = (int'(pump_r) < PUMP_COUNT);
  assign pump_ok_in = (int'(in_data.pump) < PUMP_COUNT);
  assign out_free   = !out_valid_r || out_ready;

  // dose request goes out in the accept cycle
  assign arith_req.start  = in_valid && in_ready && (in_data.cmd == mpdt_pkg::CMD_DOSE)
                          && pump_ok_in;
  assign arith_req.flow   = flow_r[in_data.pump];
  assign arith_req.volume = in_data.volume_centiml;

  // shared tick decrementer
  always_comb begin
    tick_cur = remaining_r[tick_idx_r];
    tick_dec = (tick_cur == '0) ? tick_cur : tick_cur - 1'b1;
  end

  // command sequencer and pump state
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    pump_nxt      = pump_r;
    runtime_nxt   = runtime_r;
    dosed_nxt     = dosed_r;
    tick_idx_nxt  = tick_idx_r;
    remaining_nxt = remaining_r;
    active_nxt    = active_r;
    flow_nxt      = flow_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    active_pad    = PAD_W'(active_r);

    // flow register writes
    if (cfg_valid && cfg_index < mpdt_pkg::CFG_IDX_W'(mpdt_pkg::FLOW_REGS)) begin
      flow_nxt[cfg_index[mpdt_pkg::FLOW_IDX_W-1:0]] = cfg_data;
    end

    unique case (state_r)
      T_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = in_data.cmd;
          pump_nxt     = in_data.pump;
          runtime_nxt  = '0;
          dosed_nxt    = '0;
          tick_idx_nxt = '0;
          unique case (in_data.cmd)
            mpdt_pkg::CMD_TICK: state_nxt = T_TICK;
            mpdt_pkg::CMD_DOSE: state_nxt = pump_ok_in ? T_DOSE : T_FIN;
            default:            state_nxt = T_FIN;
          endcase
        end
      end
      T_TICK: begin
        if (active_r[tick_idx_r]) begin
          remaining_nxt[tick_idx_r] = tick_dec;
          if (tick_dec == '0) begin
            active_nxt[tick_idx_r] = 1'b0;
          end
        end
        if (tick_idx_r == IDX_W'(PUMP_COUNT - 1)) begin
          state_nxt = T_FIN;
        end else begin
          tick_idx_nxt = tick_idx_r + 1'b1;
        end
      end
      T_DOSE: begin
        if (arith_rsp.done) begin
          runtime_nxt = arith_rsp.runtime;
          dosed_nxt   = arith_rsp.dosed;
          state_nxt   = T_FIN;
        end
      end
      T_FIN: begin
        if (out_free) begin
          case (cmd_r)
            mpdt_pkg::CMD_DOSE: begin
              for (int i = 0; i < PUMP_COUNT; i++) begin
                if (pump_ok && runtime_r != '0 && int'(pump_r) == i) begin
                  remaining_nxt[i] = mpdt_pkg::CNT_W'(runtime_r);
                  active_nxt[i]    = 1'b1;
                end
              end
            end
            mpdt_pkg::CMD_START: begin
              for (int i = 0; i < PUMP_COUNT; i++) begin
                if (pump_ok && int'(pump_r) == i) begin
                  remaining_nxt[i] = mpdt_pkg::MANUAL_CAP_MS;
                  active_nxt[i]    = 1'b1;
                end
              end
            end
            mpdt_pkg::CMD_STOP: begin
              for (int i = 0; i < PUMP_COUNT; i++) begin
                if (pump_ok && int'(pump_r) == i) begin
                  active_nxt[i] = 1'b0;
                end
              end
            end
            mpdt_pkg::CMD_STOP_ALL: begin
              for (int i = 0; i < PUMP_COUNT; i++) begin
                remaining_nxt[i] = '0;
              end
              active_nxt = '0;
            end
            default: begin
            end
          endcase
          active_pad            = PAD_W'(active_nxt);
          out_nxt.dosed_centiml = dosed_r;
          out_nxt.pump_on       = active_pad[mpdt_pkg::PUMP_ON_W-1:0];
          out_valid_nxt         = 1'b1;
          state_nxt             = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= '0;
      for (int i = 0; i < PUMP_COUNT; i++) begin
        remaining_r[i] <= '0;
      end
      for (int i = 0; i < mpdt_pkg::FLOW_REGS; i++) begin
        flow_r[i] <= mpdt_pkg::FLOW_RESET;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
      remaining_r <= remaining_nxt;
      flow_r      <= flow_nxt;
    end
    cmd_r      <= cmd_nxt;
    pump_r     <= pump_nxt;
    runtime_r  <= runtime_nxt;
    dosed_r    <= dosed_nxt;
    tick_idx_r <= tick_idx_nxt;
    out_r      <= out_nxt;
  end

  // one item at a time: ready drops right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous one in flight");

  // the dose unit only finishes while a dose is pending
  a_done_in_dose: assert property (@(posedge clk) disable iff (!rst_n)
    arith_rsp.done |-> state_r == T_DOSE)
    else $error("dose unit finished outside a dose");

  // a reported dose volume stays in range
  a_dosed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.dosed_centiml <= mpdt_pkg::DOSED_MAX)
    else $error("dosed volume out of range");

  // a running pump always has time left on its counter
  for (genvar g = 0; g < PUMP_COUNT; g++) begin : g_chk
    a_active_has_time: assert property (@(posedge clk) disable iff (!rst_n)
      active_r[g] |-> remaining_r[g] != '0)
      else $error("pump running with empty counter");
  end

endmodule

// ===== rtl/mpdt_arith.sv =====
// bit-serial dose unit: run time = volume*60000/flow capped, dosed = flow*run time/60000
module mpdt_arith (
  input  logic                clk,
  input  logic                rst_n,
  input  mpdt_pkg::arith_req_t req,
  output mpdt_pkg::arith_rsp_t rsp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DCHK = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_CAP  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam int LO_W = mpdt_pkg::PROD_W - mpdt_pkg::FLOW_W;
  localparam int HI_W = mpdt_pkg::PROD_W - mpdt_pkg::RT_W;

  logic [2:0]                        state_r, state_nxt;
  logic [mpdt_pkg::STEP_W-1:0]       count_r, count_nxt;
  logic [mpdt_pkg::PROD_W-1:0]       prod_r, prod_nxt;
  logic [mpdt_pkg::FLOW_W-1:0]       rem_r, rem_nxt;
  logic [mpdt_pkg::FLOW_W-1:0]       mcand_r, mcand_nxt;
  logic [mpdt_pkg::FLOW_W-1:0]       divisor_r, divisor_nxt;
  logic [mpdt_pkg::FLOW_W-1:0]       flow_r, flow_nxt;
  logic [mpdt_pkg::RT_W-1:0]         runtime_r, runtime_nxt;
  logic                              ovf_r, ovf_nxt;
  logic                              second_r, second_nxt;

  logic [mpdt_pkg::FLOW_W:0]         mul_add;
  logic [mpdt_pkg::FLOW_W:0]         trial;
  logic [mpdt_pkg::FLOW_W:0]         trial_diff;
  logic                              trial_ge;
  logic                              hi_ge;
  logic [mpdt_pkg::RT_W-1:0]         quot;
  logic [mpdt_pkg::RT_W-1:0]         rt_capped;

  // shared datapath: one narrow add for multiply, one subtract-compare for divide
  always_comb begin
    mul_add    = {1'b0, prod_r[mpdt_pkg::PROD_W-1 -: mpdt_pkg::FLOW_W]}
               + (prod_r[0] ? {1'b0, mcand_r} : '0);
    trial      = {rem_r, prod_r[mpdt_pkg::RT_W-1]};
    trial_diff = trial - {1'b0, divisor_r};
    trial_ge   = trial >= {1'b0, divisor_r};
    hi_ge      = prod_r[mpdt_pkg::PROD_W-1:mpdt_pkg::RT_W] >= HI_W'(divisor_r);
    quot       = prod_r[mpdt_pkg::RT_W-1:0];
    rt_capped  = (ovf_r || quot > mpdt_pkg::DOSE_CAP_MS) ? mpdt_pkg::DOSE_CAP_MS : quot;
  end

  // sequencer: multiply, range check, divide, cap, then the same for the delivered volume
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    prod_nxt    = prod_r;
    rem_nxt     = rem_r;
    mcand_nxt   = mcand_r;
    divisor_nxt = divisor_r;
    flow_nxt    = flow_r;
    runtime_nxt = runtime_r;
    ovf_nxt     = ovf_r;
    second_nxt  = second_r;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          if (req.flow == '0) begin
            prod_nxt    = '0;
            runtime_nxt = '0;
            state_nxt   = S_DONE;
          end else begin
            prod_nxt    = mpdt_pkg::PROD_W'(req.volume);
            mcand_nxt   = mpdt_pkg::MS_PER_MIN;
            divisor_nxt = req.flow;
            flow_nxt    = req.flow;
            ovf_nxt     = 1'b0;
            second_nxt  = 1'b0;
            count_nxt   = mpdt_pkg::STEP_W'(mpdt_pkg::MUL_STEPS - 1);
            state_nxt   = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_nxt = {mul_add, prod_r[LO_W-1:1]};
        if (count_r == '0) begin
          state_nxt = S_DCHK;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      S_DCHK: begin
        // quotient would not fit the run-time width: straight to the cap
        if (hi_ge) begin
          ovf_nxt   = 1'b1;
          state_nxt = S_CAP;
        end else begin
          rem_nxt   = prod_r[mpdt_pkg::RT_W+mpdt_pkg::FLOW_W-1:mpdt_pkg::RT_W];
          count_nxt = mpdt_pkg::STEP_W'(mpdt_pkg::DIV_STEPS - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        prod_nxt = {prod_r[mpdt_pkg::PROD_W-2:0], trial_ge};
        rem_nxt  = trial_ge ? trial_diff[mpdt_pkg::FLOW_W-1:0]
                            : trial[mpdt_pkg::FLOW_W-1:0];
        if (count_r == '0) begin
          state_nxt = second_r ? S_DONE : S_CAP;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      S_CAP: begin
        runtime_nxt = rt_capped;
        if (rt_capped == '0) begin
          state_nxt = S_DONE;
        end else begin
          prod_nxt    = mpdt_pkg::PROD_W'(rt_capped);
          mcand_nxt   = flow_r;
          divisor_nxt = mpdt_pkg::MS_PER_MIN;
          second_nxt  = 1'b1;
          ovf_nxt     = 1'b0;
          count_nxt   = mpdt_pkg::STEP_W'(mpdt_pkg::MUL_STEPS - 1);
          state_nxt   = S_MUL;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    count_r   <= count_nxt;
    prod_r    <= prod_nxt;
    rem_r     <= rem_nxt;
    mcand_r   <= mcand_nxt;
    divisor_r <= divisor_nxt;
    flow_r    <= flow_nxt;
    runtime_r <= runtime_nxt;
    ovf_r     <= ovf_nxt;
    second_r  <= second_nxt;
  end

  // answer
  assign rsp.busy    = (state_r != S_IDLE);
  assign rsp.done    = (state_r == S_DONE);
  assign rsp.runtime = runtime_r;
  assign rsp.dosed   = prod_r[mpdt_pkg::DOSED_W-1:0];

  // partial remainder stays below the divisor through every divide step
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < divisor_r)
    else $error("partial remainder not below divisor");

  // reported run time never exceeds the dose cap
  a_runtime_capped: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> rsp.runtime <= mpdt_pkg::DOSE_CAP_MS)
    else $error("run time above dose cap");

  // a new dose is only started on an idle unit
  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == S_IDLE)
    else $error("dose started while unit busy");

endmodule
